>>> hdl/svsd_pkg.sv
// Shared constants and types of the space vector PWM sector and duty calculator.
package svsd_pkg;

	// Widths of the channel fields.
	localparam int FIELD_W   = 16;
	localparam int PERIOD_W  = 16;
	localparam int SECTOR_W  = 3;

	// Default voltage precision and the reset value of the period register.
	localparam int VOLT_WIDTH_DEF = 16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

	// sqrt(3) in Q2.14.
	localparam logic signed [15:0] SQRT3_Q14 = 16'sd28378;
	localparam int SQRT3_FRAC = 14;

	// X, Y and Z stay within about 1.37 periods, active times are never negative.
	localparam int XYZ_W  = 20;
	localparam int TIME_W = 19;
	localparam int SUM_W  = 20;
	localparam int DIVD_W = TIME_W + PERIOD_W;
	localparam int QUO_W  = PERIOD_W;

	// Sector numbers; zero marks the zero vector.
	localparam logic [SECTOR_W-1:0] SEC_ZERO = 3'd0;
	localparam logic [SECTOR_W-1:0] SEC_1    = 3'd1;
	localparam logic [SECTOR_W-1:0] SEC_2    = 3'd2;
	localparam logic [SECTOR_W-1:0] SEC_3    = 3'd3;
	localparam logic [SECTOR_W-1:0] SEC_4    = 3'd4;
	localparam logic [SECTOR_W-1:0] SEC_5    = 3'd5;
	localparam logic [SECTOR_W-1:0] SEC_6    = 3'd6;

	// Per-item state that rides along the divider stages.
	typedef struct packed {
		logic [TIME_W-1:0]   ta;
		logic [TIME_W-1:0]   tb;
		logic [SECTOR_W-1:0] sec;
		logic                ovm;
	} svsd_ctl_t;

endpackage

>>> hdl/svsd_if.sv
// Channel interfaces of the space vector PWM calculator: vector in, duty out, period write.
interface svsd_vec_if;
	import svsd_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [FIELD_W-1:0]  valpha;
	logic signed [FIELD_W-1:0]  vbeta;
	modport source(output valid, valpha, vbeta, input ready);
	modport sink(input valid, valpha, vbeta, output ready);
endinterface

interface svsd_duty_if;
	import svsd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PERIOD_W-1:0]   phase_u_compare;
	logic [PERIOD_W-1:0]   phase_v_compare;
	logic [PERIOD_W-1:0]   phase_w_compare;
	logic [SECTOR_W-1:0]   sector;
	logic                  overmodulated;
	modport source(output valid, phase_u_compare, phase_v_compare, phase_w_compare,
		sector, overmodulated, input ready);
	modport sink(input valid, phase_u_compare, phase_v_compare, phase_w_compare,
		sector, overmodulated, output ready);
endinterface

interface svsd_cfg_if;
	import svsd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PERIOD_W-1:0]   data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> hdl/svpwm_sector_duty_calc.sv
// Top level of the seven-segment space vector PWM sector and duty calculator.
// One alpha/beta vector is accepted per clock while the output is not stalled; its three
// compare counts, sector and overmodulation flag pass the front stages, the divider load
// register, the dividers and the output register. The restoring dividers rescale
// overmodulated active times, one quotient bit per stage over 16 stages. The whole pipeline
// holds while a finished result waits at the output. The period register is written over the
// configuration channel and must only change while no vector is in flight.
module svpwm_sector_duty_calc #(
	parameter int VOLT_WIDTH = svsd_pkg::VOLT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	svsd_vec_if.sink    vec_in,
	svsd_duty_if.source duty_out,
	svsd_cfg_if.sink    cfg
);
	import svsd_pkg::*;

	localparam int A3P_W = VOLT_WIDTH + 16;
	localparam int A3_W  = A3P_W - SQRT3_FRAC;
	localparam int D_W   = A3_W + 1;
	localparam int M_W   = D_W + PERIOD_W + 1;
	localparam int NDIV  = QUO_W;

	logic                  advance;
	logic [PERIOD_W-1:0]   period_q;
	logic signed [PERIOD_W:0] ps;

	// Period register; writes are always taken.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg.valid) begin
			period_q <= cfg.data;
		end
	end
	assign ps = signed'({1'b0, period_q});

	// The whole pipeline moves when the output register is free or being emptied.
	logic out_valid_q;
	assign advance      = !out_valid_q || duty_out.ready;
	assign vec_in.ready = advance;

	// Stage 1: take the low voltage bits, zero extended when wider than the field.
	logic signed [VOLT_WIDTH-1:0] va_in, vb_in, va_s1, vb_s1;
	logic v_s1;
	if (VOLT_WIDTH <= FIELD_W) begin : g_narrow
		assign va_in = vec_in.valpha[VOLT_WIDTH-1:0];
		assign vb_in = vec_in.vbeta[VOLT_WIDTH-1:0];
	end else begin : g_wide
		assign va_in = {{(VOLT_WIDTH-FIELD_W){1'b0}}, vec_in.valpha};
		assign vb_in = {{(VOLT_WIDTH-FIELD_W){1'b0}}, vec_in.vbeta};
	end

	// Stage 2: alpha times sqrt(3), floored back to integer scale.
	logic signed [A3P_W-1:0] a3_prod;
	logic signed [A3_W-1:0]  a3_s2;
	logic signed [VOLT_WIDTH-1:0] vb_s2;
	logic v_s2;
	assign a3_prod = A3P_W'(SQRT3_Q14) * A3P_W'(va_s1);

	// Stage 3: X, Y and Z as products with the period.
	logic signed [D_W-1:0] dz, dy;
	logic signed [M_W-1:0] x_prod, z_prod, y_prod;
	logic signed [XYZ_W-1:0] x_s3, y_s3, z_s3;
	logic v_s3;
	assign dz     = D_W'(a3_s2) - D_W'(vb_s2);
	assign dy     = -D_W'(a3_s2) - D_W'(vb_s2);
	assign x_prod = M_W'(vb_s2) * M_W'(ps);
	assign z_prod = M_W'(dz) * M_W'(ps);
	assign y_prod = M_W'(dy) * M_W'(ps);

	// Stage 4: sector from the signs and the two active times.
	logic [2:0] ncode;
	logic signed [XYZ_W-1:0] ta_c, tb_c;
	logic [SECTOR_W-1:0] sec_c;
	logic [TIME_W-1:0] ta_s4, tb_s4;
	logic [SUM_W-1:0] sum_s4;
	logic [SECTOR_W-1:0] sec_s4;
	logic v_s4;
	assign ncode = {z_s3 > 0, y_s3 > 0, x_s3 > 0};
	always_comb begin
		sec_c = SEC_ZERO;
		ta_c  = '0;
		tb_c  = '0;
		case (ncode)
			3'd5: begin sec_c = SEC_1; ta_c = z_s3;  tb_c = x_s3;  end
			3'd1: begin sec_c = SEC_2; ta_c = -z_s3; tb_c = -y_s3; end
			3'd3: begin sec_c = SEC_3; ta_c = x_s3;  tb_c = y_s3;  end
			3'd2: begin sec_c = SEC_4; ta_c = -x_s3; tb_c = -z_s3; end
			3'd6: begin sec_c = SEC_5; ta_c = y_s3;  tb_c = z_s3;  end
			3'd4: begin sec_c = SEC_6; ta_c = -y_s3; tb_c = -x_s3; end
			default: begin sec_c = SEC_ZERO; end
		endcase
	end

	// Stage 5: overmodulation test and the scaled dividends.
	logic ovm_c;
	logic [DIVD_W-1:0] dda_c, ddb_c;
	assign ovm_c = (sec_s4 != SEC_ZERO) && (sum_s4 > SUM_W'(period_q));
	assign dda_c = DIVD_W'(ta_s4) * DIVD_W'(period_q);
	assign ddb_c = DIVD_W'(tb_s4) * DIVD_W'(period_q);

	// Divider stages; index 0 is loaded by stage 5, each later index adds one quotient bit.
	// The low word starts as the low dividend bits and ends as the quotient.
	logic [SUM_W-1:0]  rema_sdiv [NDIV+1];
	logic [SUM_W-1:0]  remb_sdiv [NDIV+1];
	logic [QUO_W-1:0]  loa_sdiv  [NDIV+1];
	logic [QUO_W-1:0]  lob_sdiv  [NDIV+1];
	logic [SUM_W-1:0]  dvs_sdiv  [NDIV+1];
	svsd_ctl_t         ctl_sdiv  [NDIV+1];
	logic [NDIV:0]     v_sdiv;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [SUM_W:0] tra, trb;
		logic ga, gb;
		assign tra = {rema_sdiv[k], loa_sdiv[k][QUO_W-1]};
		assign trb = {remb_sdiv[k], lob_sdiv[k][QUO_W-1]};
		assign ga  = tra >= {1'b0, dvs_sdiv[k]};
		assign gb  = trb >= {1'b0, dvs_sdiv[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sdiv[k+1] <= 1'b0;
			end else if (advance) begin
				v_sdiv[k+1] <= v_sdiv[k];
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				rema_sdiv[k+1] <= ga ? SUM_W'(tra - {1'b0, dvs_sdiv[k]}) : SUM_W'(tra);
				remb_sdiv[k+1] <= gb ? SUM_W'(trb - {1'b0, dvs_sdiv[k]}) : SUM_W'(trb);
				loa_sdiv[k+1]  <= {loa_sdiv[k][QUO_W-2:0], ga};
				lob_sdiv[k+1]  <= {lob_sdiv[k][QUO_W-2:0], gb};
				dvs_sdiv[k+1]  <= dvs_sdiv[k];
				ctl_sdiv[k+1]  <= ctl_sdiv[k];
			end
		end
	end

	// Output stage: final times, half zero time and the phase assignment.
	svsd_ctl_t ctl_l;
	logic [PERIOD_W-1:0] ta_f, tb_f, t0, full, mid, half;
	logic [PERIOD_W:0] rest;
	assign ctl_l = ctl_sdiv[NDIV];
	assign ta_f  = ctl_l.ovm ? loa_sdiv[NDIV] : ctl_l.ta[PERIOD_W-1:0];
	assign tb_f  = ctl_l.ovm ? lob_sdiv[NDIV] : ctl_l.tb[PERIOD_W-1:0];
	assign rest  = {1'b0, period_q} - {1'b0, ta_f} - {1'b0, tb_f};
	assign t0    = rest[PERIOD_W:1];
	assign full  = ta_f + tb_f + t0;
	assign mid   = tb_f + t0;
	assign half  = period_q >> 1;

	logic [PERIOD_W-1:0] u_c, vv_c, w_c;
	always_comb begin
		case (ctl_l.sec)
			SEC_1:   begin u_c = full; vv_c = t0;   w_c = mid;  end
			SEC_2:   begin u_c = mid;  vv_c = t0;   w_c = full; end
			SEC_3:   begin u_c = t0;   vv_c = mid;  w_c = full; end
			SEC_4:   begin u_c = t0;   vv_c = full; w_c = mid;  end
			SEC_5:   begin u_c = mid;  vv_c = full; w_c = t0;   end
			SEC_6:   begin u_c = full; vv_c = mid;  w_c = t0;   end
			default: begin u_c = half; vv_c = half; w_c = half; end
		endcase
	end

	// Valid bits of the front stages and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_sdiv[0]   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= vec_in.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_sdiv[0]   <= v_s4;
			out_valid_q <= v_sdiv[NDIV];
		end
	end

	// Payload of the front stages and the output register.
	logic [PERIOD_W-1:0] u_q, v_q, w_q;
	logic [SECTOR_W-1:0] sec_q;
	logic ovm_q;
	always_ff @(posedge clk) begin
		if (advance) begin
			va_s1  <= va_in;
			vb_s1  <= vb_in;
			a3_s2  <= signed'(a3_prod[A3P_W-1:SQRT3_FRAC]);
			vb_s2  <= vb_s1;
			x_s3   <= signed'(x_prod[XYZ_W+VOLT_WIDTH-2:VOLT_WIDTH-1]);
			z_s3   <= signed'(z_prod[XYZ_W+VOLT_WIDTH-1:VOLT_WIDTH]);
			y_s3   <= signed'(y_prod[XYZ_W+VOLT_WIDTH-1:VOLT_WIDTH]);
			ta_s4  <= TIME_W'(ta_c);
			tb_s4  <= TIME_W'(tb_c);
			sum_s4 <= SUM_W'(TIME_W'(ta_c)) + SUM_W'(TIME_W'(tb_c));
			sec_s4 <= sec_c;
			rema_sdiv[0] <= SUM_W'(dda_c[DIVD_W-1:QUO_W]);
			remb_sdiv[0] <= SUM_W'(ddb_c[DIVD_W-1:QUO_W]);
			loa_sdiv[0]  <= dda_c[QUO_W-1:0];
			lob_sdiv[0]  <= ddb_c[QUO_W-1:0];
			dvs_sdiv[0]  <= sum_s4;
			ctl_sdiv[0]  <= '{ta: ta_s4, tb: tb_s4, sec: sec_s4, ovm: ovm_c};
			u_q   <= u_c;
			v_q   <= vv_c;
			w_q   <= w_c;
			sec_q <= ctl_l.sec;
			ovm_q <= ctl_l.ovm;
		end
	end

	assign duty_out.valid           = out_valid_q;
	assign duty_out.phase_u_compare = u_q;
	assign duty_out.phase_v_compare = v_q;
	assign duty_out.phase_w_compare = w_q;
	assign duty_out.sector          = sec_q;
	assign duty_out.overmodulated   = ovm_q;

endmodule
